// File: rtl/mshm_pkg.sv
// Package for the microphone signal health monitor.
// Holds widths, limits, register indexes, verdict codes and sequencer states.
// Used by mic_signal_health_monitor; depends on nothing.
package mshm_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned LevelW     = 16;
  localparam int unsigned SumW       = 32;
  localparam int unsigned MaxSamples = 65536;
  localparam int unsigned CountW     = $clog2(MaxSamples + 1);
  localparam int unsigned MaxFrames  = 64;
  localparam int unsigned FrameCap   = (MaxFrames < 127) ? MaxFrames : 127;
  localparam int unsigned FrameCntW  = 7;
  localparam int unsigned MeanCap    = 32768;
  localparam int unsigned DivSteps   = SumW;
  localparam int unsigned StepW      = $clog2(DivSteps);

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0] RegNoSignal = 2'd0;
  localparam logic [CfgIdxW-1:0] RegClip     = 2'd1;

  localparam logic [LevelW-1:0] NoSignalReset = 16'd1;
  localparam logic [LevelW-1:0] ClipReset     = 16'd32767;

  typedef enum logic [1:0] {
    VERDICT_SANE      = 2'd0,
    VERDICT_NO_SIGNAL = 2'd1,
    VERDICT_CLIPPING  = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// File: rtl/mic_signal_health_monitor.sv
// Top level of the microphone signal health monitor.
// Accumulates per-sample statistics and runs a shared serial divider per test.
// Depends on mshm_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one signed sample per item
//   with frame_end_i and test_end_i marks. Output channel (out_valid_o /
//   out_stall_i) carries one report per test. An item moves on a rising edge
//   with valid high and stall low.
//   For a sample without test_end, peak, sum, count and frame
//   flags update in the cycle it is accepted, and the next one can follow.
//   A test_end item starts the mean division: one quotient bit per cycle
//   through a single subtractor, then the done state loads the report
//   register. in_stall_o is high through the division and the done state,
//   and the done state lasts while an earlier report still sits stalled
//   in the report register.
//   While the receiver stalls, the report holds and new samples are still
//   taken; a further test_end waits in the done state until the report
//   register is free.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) land directly in the threshold registers.
//   Reset sets the thresholds to 1 and 32767 and clears all statistics; no
//   clearing pass is needed.
module mic_signal_health_monitor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mshm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mshm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [mshm_pkg::SampleW-1:0] sample_i,
  input  logic                            frame_end_i,
  input  logic                            test_end_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mshm_pkg::LevelW-1:0]     peak_level_o,
  output logic [mshm_pkg::LevelW-1:0]     mean_level_o,
  output logic [mshm_pkg::FrameCntW-1:0]  stuck_frames_o,
  output logic [mshm_pkg::FrameCntW-1:0]  zero_frames_o,
  output logic [1:0]                      verdict_o
);

  localparam int unsigned LW = mshm_pkg::LevelW;
  localparam int unsigned SW = mshm_pkg::SumW;
  localparam int unsigned CW = mshm_pkg::CountW;
  localparam int unsigned FW = mshm_pkg::FrameCntW;

  mshm_pkg::state_e state_q, state_d;

  logic [LW-1:0] no_signal_q, clip_q;

  logic [LW-1:0] peak_q, peak_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [CW-1:0] count_q, count_d;
  logic          all_m1_q, all_m1_d;
  logic          zflag_q, zflag_d;
  logic [FW-1:0] stuck_cnt_q, stuck_cnt_d;
  logic [FW-1:0] zero_cnt_q, zero_cnt_d;

  // report fields waiting for the division
  logic [LW-1:0]          pend_peak_q;
  logic [FW-1:0]          pend_stuck_q;
  logic [FW-1:0]          pend_zero_q;
  mshm_pkg::verdict_e     pend_verdict_q, verdict_d;

  // serial divider
  logic [SW-1:0]                 quo_q;
  logic [CW-1:0]                 rem_q, div_q;
  logic [mshm_pkg::StepW-1:0]    step_q;
  logic [CW:0]                   trial;
  logic                          trial_ge;
  logic [CW:0]                   trial_diff;
  logic [LW-1:0]                 mean_val;

  logic            out_valid_q;
  logic [LW-1:0]   out_peak_q, out_mean_q;
  logic [FW-1:0]   out_stuck_q, out_zero_q;
  mshm_pkg::verdict_e out_verdict_q;

  logic            in_acc, out_free, load_out;
  logic [LW-1:0]   mag;
  logic [SW:0]     sum_wide;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------- accumulation ----------------
  always_comb begin
    mag = sample_i[LW-1] ? (~sample_i + 16'd1) : sample_i;

    peak_d = (mag > peak_q) ? mag : peak_q;

    sum_wide = {1'b0, sum_q} + {{(SW + 1 - LW){1'b0}}, mag};
    if (count_q < CW'(mshm_pkg::MaxSamples)) begin
      sum_d   = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
      count_d = count_q + 1'b1;
    end else begin
      sum_d   = sum_q;
      count_d = count_q;
    end

    all_m1_d    = all_m1_q && (sample_i == 16'hFFFF);
    zflag_d     = zflag_q && (sample_i == 16'h0000);
    stuck_cnt_d = stuck_cnt_q;
    zero_cnt_d  = zero_cnt_q;
    if (frame_end_i || test_end_i) begin
      if (all_m1_d && (stuck_cnt_q < FW'(mshm_pkg::FrameCap))) begin
        stuck_cnt_d = stuck_cnt_q + 1'b1;
      end
      if (zflag_d && (zero_cnt_q < FW'(mshm_pkg::FrameCap))) begin
        zero_cnt_d = zero_cnt_q + 1'b1;
      end
      all_m1_d = 1'b1;
      zflag_d  = 1'b1;
    end

    // no signal is checked before clipping
    if (peak_d <= no_signal_q) begin
      verdict_d = mshm_pkg::VERDICT_NO_SIGNAL;
    end else if (peak_d >= clip_q) begin
      verdict_d = mshm_pkg::VERDICT_CLIPPING;
    end else begin
      verdict_d = mshm_pkg::VERDICT_SANE;
    end
  end

  // ---------------- divider step ----------------
  always_comb begin
    trial      = {rem_q, quo_q[SW-1]};
    trial_ge   = trial >= {1'b0, div_q};
    trial_diff = trial - {1'b0, div_q};
    if (div_q == '0) begin
      mean_val = '0;
    end else if (quo_q > SW'(mshm_pkg::MeanCap)) begin
      mean_val = LW'(mshm_pkg::MeanCap);
    end else begin
      mean_val = quo_q[LW-1:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (state_q)
      mshm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && test_end_i) begin
          state_d = mshm_pkg::ST_DIV;
        end
      end
      mshm_pkg::ST_DIV: begin
        if (step_q == mshm_pkg::StepW'(mshm_pkg::DivSteps - 1)) begin
          state_d = mshm_pkg::ST_DONE;
        end
      end
      mshm_pkg::ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = mshm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mshm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mshm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_signal_q <= mshm_pkg::NoSignalReset;
      clip_q      <= mshm_pkg::ClipReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mshm_pkg::RegNoSignal: no_signal_q <= cfg_data_i;
        mshm_pkg::RegClip:     clip_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      all_m1_q    <= 1'b1;
      zflag_q     <= 1'b1;
      stuck_cnt_q <= '0;
      zero_cnt_q  <= '0;
    end else if (in_acc) begin
      if (test_end_i) begin
        peak_q      <= '0;
        sum_q       <= '0;
        count_q     <= '0;
        all_m1_q    <= 1'b1;
        zflag_q     <= 1'b1;
        stuck_cnt_q <= '0;
        zero_cnt_q  <= '0;
      end else begin
        peak_q      <= peak_d;
        sum_q       <= sum_d;
        count_q     <= count_d;
        all_m1_q    <= all_m1_d;
        zflag_q     <= zflag_d;
        stuck_cnt_q <= stuck_cnt_d;
        zero_cnt_q  <= zero_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (in_acc && test_end_i) begin
      step_q <= '0;
    end else if (state_q == mshm_pkg::ST_DIV) begin
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && test_end_i) begin
      quo_q          <= sum_d;
      div_q          <= count_d;
      rem_q          <= '0;
      pend_peak_q    <= peak_d;
      pend_stuck_q   <= stuck_cnt_d;
      pend_zero_q    <= zero_cnt_d;
      pend_verdict_q <= verdict_d;
    end else if (state_q == mshm_pkg::ST_DIV) begin
      quo_q <= {quo_q[SW-2:0], trial_ge};
      rem_q <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_peak_q    <= pend_peak_q;
      out_mean_q    <= mean_val;
      out_stuck_q   <= pend_stuck_q;
      out_zero_q    <= pend_zero_q;
      out_verdict_q <= pend_verdict_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign peak_level_o   = out_peak_q;
  assign mean_level_o   = out_mean_q;
  assign stuck_frames_o = out_stuck_q;
  assign zero_frames_o  = out_zero_q;
  assign verdict_o      = out_verdict_q;

`ifndef SYNTH
  a_test_end_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && test_end_i) |=> (state_q == mshm_pkg::ST_DIV && count_q == '0))
    else $error("test end did not start division with cleared state");

  a_report_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == mshm_pkg::ST_DONE))
    else $error("report appeared outside the done state");

  a_div_clear_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mshm_pkg::ST_DIV) |-> (sum_q == '0 && peak_q == '0 && stuck_cnt_q == '0))
    else $error("accumulators not cleared during division");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CW'(mshm_pkg::MaxSamples)) &&
    (stuck_cnt_q <= FW'(mshm_pkg::FrameCap)) && (zero_cnt_q <= FW'(mshm_pkg::FrameCap)))
    else $error("counter beyond its limit");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mshm_pkg::ST_DIV && div_q != '0) |-> (rem_q < div_q))
    else $error("divider remainder out of range");
`endif

endmodule

// File: sim/tb_mic_signal_health_monitor.sv
// Self-checking testbench for mic_signal_health_monitor.
// Drives sample items, predicts each test report and checks it field by field.
// Depends on mshm_pkg and the RTL top level.
module tb_mic_signal_health_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [mshm_pkg::SampleW-1:0] sample;
    logic                         frame_end;
    logic                         test_end;
  } mic_item_t;

  typedef struct {
    logic [mshm_pkg::LevelW-1:0]    peak;
    logic [mshm_pkg::LevelW-1:0]    mean;
    logic [mshm_pkg::FrameCntW-1:0] pinned;
    logic [mshm_pkg::FrameCntW-1:0] silent;
    mshm_pkg::verdict_e             verdict;
  } health_report_t;

  typedef enum int unsigned {
    FK_PINNED,
    FK_ZERO,
    FK_FULL,
    FK_QUIET,
    FK_EXTREME,
    FK_MODERATE
  } frame_kind_e;

  localparam int unsigned SettleCycles = 40;
  // indexes past the register list
  localparam logic [mshm_pkg::CfgIdxW-1:0] RegSpare0 = 2'd2;
  localparam logic [mshm_pkg::CfgIdxW-1:0] RegSpare1 = 2'd3;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_we_i = 1'b0;
  logic [mshm_pkg::CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [mshm_pkg::CfgDataW-1:0]      cfg_data_i = '0;
  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic signed [mshm_pkg::SampleW-1:0] sample_i = '0;
  logic                               frame_end_i = 1'b0;
  logic                               test_end_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic [mshm_pkg::LevelW-1:0]        peak_level_o;
  logic [mshm_pkg::LevelW-1:0]        mean_level_o;
  logic [mshm_pkg::FrameCntW-1:0]     stuck_frames_o;
  logic [mshm_pkg::FrameCntW-1:0]     zero_frames_o;
  logic [1:0]                         verdict_o;

  mic_signal_health_monitor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .frame_end_i    (frame_end_i),
    .test_end_i     (test_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .peak_level_o   (peak_level_o),
    .mean_level_o   (mean_level_o),
    .stuck_frames_o (stuck_frames_o),
    .zero_frames_o  (zero_frames_o),
    .verdict_o      (verdict_o)
  );

  mic_item_t      pending_items[$];
  health_report_t expected_reports[$];
  mic_item_t      cur_item;
  int unsigned    items_queued = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;

  // predictor state
  logic [mshm_pkg::LevelW-1:0]    thr_no_signal = mshm_pkg::NoSignalReset;
  logic [mshm_pkg::LevelW-1:0]    thr_clip = mshm_pkg::ClipReset;
  logic [mshm_pkg::LevelW-1:0]    acc_peak = '0;
  logic [mshm_pkg::SumW-1:0]      acc_sum = '0;
  logic [mshm_pkg::CountW-1:0]    acc_count = '0;
  logic                           frame_minus_one = 1'b1;
  logic                           frame_zero = 1'b1;
  logic [mshm_pkg::FrameCntW-1:0] stuck_frames = '0;
  logic [mshm_pkg::FrameCntW-1:0] zero_frames = '0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic health_predict(input mic_item_t it);
    logic [mshm_pkg::LevelW-1:0] mag;
    logic [mshm_pkg::SumW:0]     sum_ext;
    logic [mshm_pkg::SumW-1:0]   quot;
    health_report_t              rep;
    mag = it.sample[mshm_pkg::SampleW-1] ? (~it.sample + 16'd1) : it.sample;  // -32768 -> 0x8000
    if (mag > acc_peak) acc_peak = mag;
    if (acc_count < mshm_pkg::MaxSamples) begin
      sum_ext = {1'b0, acc_sum} + {17'd0, mag};
      acc_sum = sum_ext[mshm_pkg::SumW] ? '1 : sum_ext[mshm_pkg::SumW-1:0];
      acc_count = acc_count + 1'b1;
    end
    if (it.sample != 16'hFFFF) frame_minus_one = 1'b0;
    if (it.sample != 16'h0000) frame_zero = 1'b0;
    if (it.frame_end || it.test_end) begin
      if (frame_minus_one && stuck_frames < mshm_pkg::FrameCap)
        stuck_frames = stuck_frames + 1'b1;
      if (frame_zero && zero_frames < mshm_pkg::FrameCap) zero_frames = zero_frames + 1'b1;
      frame_minus_one = 1'b1;
      frame_zero = 1'b1;
    end
    if (it.test_end) begin
      quot = (acc_count != 0) ? acc_sum / {15'd0, acc_count} : '0;
      if (quot > mshm_pkg::MeanCap) quot = mshm_pkg::MeanCap;
      rep.peak = acc_peak;
      rep.mean = quot[mshm_pkg::LevelW-1:0];
      rep.pinned = stuck_frames;
      rep.silent = zero_frames;
      if (acc_peak <= thr_no_signal) rep.verdict = mshm_pkg::VERDICT_NO_SIGNAL;
      else if (acc_peak >= thr_clip) rep.verdict = mshm_pkg::VERDICT_CLIPPING;
      else rep.verdict = mshm_pkg::VERDICT_SANE;
      expected_reports.insert(expected_reports.size(), rep);
      acc_peak = '0;
      acc_sum = '0;
      acc_count = '0;
      stuck_frames = '0;
      zero_frames = '0;
    end
  endtask

  // driver: payload holds while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) health_predict(cur_item);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          sample_i <= cur_item.sample;
          frame_end_i <= cur_item.frame_end;
          test_end_i <= cur_item.test_end;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    health_report_t exp_rep;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $error("report with none expected: peak %0d mean %0d", peak_level_o, mean_level_o);
          mismatch_count++;
        end else begin
          exp_rep = expected_reports.pop_front();
          check_field("peak_level", exp_rep.peak, peak_level_o);
          check_field("mean_level", exp_rep.mean, mean_level_o);
          check_field("stuck_frames", exp_rep.pinned, stuck_frames_o);
          check_field("zero_frames", exp_rep.silent, zero_frames_o);
          check_field("verdict", exp_rep.verdict, verdict_o);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic queue_item(input logic [mshm_pkg::SampleW-1:0] smp, input logic fe,
                            input logic te);
    mic_item_t it;
    it.sample = smp;
    it.frame_end = fe;
    it.test_end = te;
    pending_items.insert(pending_items.size(), it);
    items_queued++;
  endtask

  function automatic logic [mshm_pkg::SampleW-1:0] pick_sample(input frame_kind_e kind);
    logic [31:0] rnd;
    rnd = $urandom;
    case (kind)
      FK_PINNED:     rnd = 32'hFFFF_FFFF;
      FK_ZERO:       rnd = '0;
      FK_FULL:       ;
      FK_QUIET:      rnd = $urandom_range(6) - 3;
      FK_EXTREME: begin
        case ($urandom_range(5))
          0: rnd = 32'h8000;
          1: rnd = 32'h7FFF;
          2: rnd = 32'h8001;
          3: rnd = 32'h0001;
          4: rnd = 32'hFFFF;
          default: rnd = '0;
        endcase
      end
      default:       rnd = $urandom_range(8192) - 4096;
    endcase
    return rnd[mshm_pkg::SampleW-1:0];
  endfunction

  task automatic queue_frame(input frame_kind_e kind, input int unsigned len, input bit noisy,
                             input bit ends_test);
    logic [mshm_pkg::SampleW-1:0] smp;
    bit                           last;
    for (int unsigned i = 0; i < len; i++) begin
      smp = pick_sample(kind);
      // occasional stray sample breaks a stuck frame
      if (noisy && kind <= FK_ZERO && $urandom_range(11) == 0) smp = pick_sample(FK_FULL);
      last = (i == len - 1);
      queue_item(smp, last && (!ends_test || $urandom_range(1) == 1), last && ends_test);
    end
  endtask

  task automatic queue_random_test();
    int unsigned nframes;
    int unsigned len;
    nframes = $urandom_range(1, 6);
    for (int unsigned f = 0; f < nframes; f++) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      queue_frame(frame_kind_e'($urandom_range(5)), len, 1'b1, f == nframes - 1);
    end
  endtask

  // enough stuck frames of one kind to hit the counter ceiling
  task automatic queue_stuck_burst();
    frame_kind_e kind;
    frame_kind_e fk;
    int unsigned nframes;
    kind = $urandom_range(1) ? FK_PINNED : FK_ZERO;
    nframes = $urandom_range(mshm_pkg::FrameCap + 2, mshm_pkg::FrameCap + 8);
    for (int unsigned f = 0; f < nframes; f++) begin
      fk = ($urandom_range(9) == 0) ? frame_kind_e'($urandom_range(5)) : kind;
      queue_frame(fk, $urandom_range(1, 3), 1'b0, f == nframes - 1);
    end
  endtask

  task automatic queue_segment(input int unsigned target);
    int unsigned start;
    start = items_queued;
    queue_stuck_burst();
    while (items_queued - start < target) queue_random_test();
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mshm_pkg::CfgIdxW-1:0] idx,
                           input logic [mshm_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mshm_pkg::RegNoSignal: thr_no_signal = data;
      mshm_pkg::RegClip:     thr_clip = data;
      default:               ;
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 22;
    recv_stall_pct = 81;
    // unused indexes must be ignored
    write_reg(RegSpare0, 16'hFFFF);
    write_reg(RegSpare1, 16'h0000);

    // directed, reset thresholds
    queue_item(16'h7FFF, 1'b1, 1'b0);
    queue_item(16'h8000, 1'b1, 1'b0);
    queue_item(16'h0000, 1'b0, 1'b0);
    queue_item(16'hFFFF, 1'b0, 1'b1);  // test end alone closes the frame
    queue_item(16'hFFFF, 1'b1, 1'b1);
    queue_item(16'h0000, 1'b0, 1'b0);
    queue_item(16'h0000, 1'b1, 1'b0);
    queue_item(16'h0000, 1'b0, 1'b1);
    queue_item(16'h0001, 1'b0, 1'b0);
    queue_item(16'hFFFE, 1'b1, 1'b0);
    queue_item(16'h0064, 1'b0, 1'b0);
    queue_item(16'hFF9C, 1'b1, 1'b1);
    queue_item(16'h8001, 1'b0, 1'b0);
    queue_item(16'h7FFF, 1'b0, 1'b1);
    queue_item(16'h0002, 1'b0, 1'b1);
    queue_item(16'h5555, 1'b0, 1'b0);
    queue_item(16'hAAAA, 1'b1, 1'b1);
    wait_idle();

    write_reg(mshm_pkg::RegNoSignal, 16'($urandom_range(64)));
    write_reg(mshm_pkg::RegClip, 16'($urandom_range(8000, 32768)));
    queue_segment(300);
    wait_idle();

    send_idle_pct = 81;
    recv_stall_pct = 22;
    write_reg(mshm_pkg::RegNoSignal, 16'd0);
    write_reg(mshm_pkg::RegClip, 16'd32768);
    queue_segment(300);
    wait_idle();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(mshm_pkg::RegNoSignal, 16'd32768);
    write_reg(mshm_pkg::RegClip, 16'd0);
    queue_segment(300);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
